// ===== rtl/indexed_array_table_assert.svh =====
// Assertion macros shared by the table modules
`ifndef INDEXED_ARRAY_TABLE_ASSERT_SVH
`define INDEXED_ARRAY_TABLE_ASSERT_SVH
// Implication checked at every clock edge outside reset
`define IAT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent
`define IAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== rtl/iat_pkg.sv =====
// Package: opcodes, status codes and the command kinds queued between front and back
`timescale 1ns / 1ps
package iat_pkg;
	localparam int DEPTH_DEF = 64;
	localparam int QDEPTH = 2;

	typedef enum logic [2:0] {
		OP_INS_FRONT = 3'd0, OP_INS_BACK = 3'd1, OP_INS_AT = 3'd2,
		OP_REM_FIRST = 3'd3, OP_REM_LAST = 3'd4, OP_REM_AT = 3'd5,
		OP_SEARCH = 3'd6, OP_READ = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_FULL = 2'd1, ST_EMPTY = 2'd2, ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		K_NONE = 2'd0, K_INS = 2'd1, K_REM = 2'd2
	} kind_t;
endpackage

// ===== rtl/iat_front.sv =====
// Front end: checks each command against the tracked length and queues it
`timescale 1ns / 1ps
module iat_front import iat_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int LW = $clog2(DEPTH + 1),
	parameter int AW = $clog2(DEPTH)
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  logic [2:0]   opcode,
	input  logic [6:0]   position_in,
	input  logic [31:0]  value_in,
	output logic         q_valid,
	input  logic         q_pop,
	output op_t          q_op,
	output kind_t        q_kind,
	output status_t      q_status,
	output logic [AW-1:0] q_pos,
	output logic [31:0]  q_val,
	output logic [LW-1:0] q_len
);
	localparam int CW = $clog2(QDEPTH + 1);
	localparam int PW = LW + 8;
	localparam logic [LW-1:0] DMAX = LW'(DEPTH);

	op_t          op_q     [QDEPTH];
	kind_t        kind_q   [QDEPTH];
	status_t      st_q     [QDEPTH];
	logic [AW-1:0] pos_q   [QDEPTH];
	logic [31:0]  val_q    [QDEPTH];
	logic [LW-1:0] len_q   [QDEPTH];
	logic [CW-1:0] cnt_q;
	logic         rd_q, wr_q;
	logic [LW-1:0] flen_q;

	op_t          op;
	kind_t        kind;
	status_t      st;
	logic [AW-1:0] pos;
	logic [LW-1:0] nlen;
	logic [PW-1:0] p8, l8;
	logic         push;

	assign busy = (cnt_q == CW'(QDEPTH));
	assign push = start && !busy;
	assign op = op_t'(opcode);
	assign p8 = PW'(position_in);
	assign l8 = PW'(flen_q);

	always_comb begin
		kind = K_NONE;
		st = ST_OK;
		pos = '0;
		nlen = flen_q;
		case (op)
			OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
				if (flen_q == DMAX) begin
					st = ST_FULL;
				end else if (op == OP_INS_AT && p8 > l8) begin
					st = ST_RANGE;
				end else begin
					kind = K_INS;
					nlen = flen_q + 1'b1;
					if (op == OP_INS_BACK) pos = AW'(flen_q);
					else if (op == OP_INS_AT) pos = AW'(position_in);
				end
			end
			OP_REM_FIRST, OP_REM_LAST, OP_REM_AT: begin
				if (flen_q == '0) begin
					st = ST_EMPTY;
				end else if (op == OP_REM_AT && p8 >= l8) begin
					st = ST_RANGE;
				end else begin
					kind = K_REM;
					nlen = flen_q - 1'b1;
					if (op == OP_REM_LAST) pos = AW'(flen_q - 1'b1);
					else if (op == OP_REM_AT) pos = AW'(position_in);
				end
			end
			OP_READ: begin
				if (flen_q == '0) st = ST_EMPTY;
				else if (p8 >= l8) st = ST_RANGE;
				else pos = AW'(position_in);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			flen_q <= '0;
		end else begin
			if (push) flen_q <= nlen;
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + CW'(push) - CW'(q_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			op_q[wr_q] <= op;
			kind_q[wr_q] <= kind;
			st_q[wr_q] <= st;
			pos_q[wr_q] <= pos;
			val_q[wr_q] <= value_in;
			len_q[wr_q] <= nlen;
		end
	end

	assign q_valid = (cnt_q != '0);
	assign q_op = op_q[rd_q];
	assign q_kind = kind_q[rd_q];
	assign q_status = st_q[rd_q];
	assign q_pos = pos_q[rd_q];
	assign q_val = val_q[rd_q];
	assign q_len = len_q[rd_q];

`include "indexed_array_table_assert.svh"
	`IAT_ASSERT_IMP(a_cnt_max, clk, arst_n, 1'b1, cnt_q <= CW'(QDEPTH))
	`IAT_ASSERT_IMP(a_len_max, clk, arst_n, 1'b1, flen_q <= DMAX)
	`IAT_ASSERT_IMP(a_pop_valid, clk, arst_n, q_pop, q_valid)
endmodule

// ===== rtl/iat_back.sv =====
// Back end: register cell chain that shifts, searches and reads entries
`timescale 1ns / 1ps
module iat_back import iat_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int LW = $clog2(DEPTH + 1),
	parameter int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	output logic          q_pop,
	input  op_t           q_op,
	input  kind_t         q_kind,
	input  status_t       q_status,
	input  logic [AW-1:0] q_pos,
	input  logic [31:0]   q_val,
	input  logic [LW-1:0] q_len,
	output logic          done,
	output logic [1:0]    status,
	output logic          found,
	output logic [5:0]    found_position,
	output logic [31:0]   read_data,
	output logic [6:0]    length
);
	logic [31:0]   ent_q [DEPTH];
	logic [LW-1:0] blen_q;
	logic [DEPTH-1:0] hit;
	logic          any;
	logic [AW-1:0] first;

	assign q_pop = q_valid;

	always_comb begin
		for (int i = 0; i < DEPTH; i++)
			hit[i] = (ent_q[i] == q_val) && (LW'(i) < blen_q);
		any = |hit;
		first = '0;
		for (int i = DEPTH - 1; i >= 0; i--)
			if (hit[i]) first = AW'(i);
	end

	always_ff @(posedge clk) begin
		if (q_valid) begin
			for (int i = 0; i < DEPTH; i++) begin
				if (q_kind == K_INS) begin
					if (AW'(i) == q_pos) ent_q[i] <= q_val;
					else if (AW'(i) > q_pos && i > 0) ent_q[i] <= ent_q[(i > 0) ? i - 1 : 0];
				end else if (q_kind == K_REM) begin
					if (AW'(i) >= q_pos && i < DEPTH - 1)
						ent_q[i] <= ent_q[(i < DEPTH - 1) ? i + 1 : i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blen_q <= '0;
			done <= 1'b0;
		end else begin
			done <= q_valid;
			if (q_valid) blen_q <= q_len;
		end
	end

	always_ff @(posedge clk) begin
		if (q_valid) begin
			status <= q_status;
			length <= 7'(q_len);
			found <= (q_op == OP_SEARCH) && any;
			found_position <= (q_op == OP_SEARCH && any) ? 6'(first) : 6'd0;
			read_data <= (q_op == OP_READ && q_status == ST_OK) ? ent_q[q_pos] : 32'd0;
		end
	end

`include "indexed_array_table_assert.svh"
	`IAT_ASSERT_NEXT(a_done_follows, clk, arst_n, q_valid, done)
	`IAT_ASSERT_IMP(a_ok_kind, clk, arst_n, q_valid && q_kind != K_NONE, q_status == ST_OK)
	`IAT_ASSERT_IMP(a_found_ok, clk, arst_n, done && found, status == ST_OK)
endmodule

// ===== rtl/indexed_array_table.sv =====
// Top level: ordered table of unsigned 32-bit words with insert, remove, search and read
// Usage: drive opcode, position_in and value_in with start high; the command
// beat is taken on a rising edge where start is high and busy is low.
// A front end checks the command against its own copy of the length and
// writes a queue of two beats; the back end shifts a chain of DEPTH
// registers, compares all of them in parallel for search, and reads by index.
// Each command gives one result beat, marked by done for one cycle; the beat
// passes through the queue and then the output register.
// Throughput: one command per cycle, as the back end drains a beat a cycle.
// busy rises only when the queue is full, which the back end never allows
// to persist. The receiver cannot stall: results must be taken as they come.
// Reset clears the length, the queue and done; entry contents are undefined
// until written and are never read before that.
`timescale 1ns / 1ps
module indexed_array_table import iat_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  opcode,
	input  logic [6:0]  position_in,
	input  logic [31:0] value_in,
	output logic        done,
	output logic [1:0]  status,
	output logic        found,
	output logic [5:0]  found_position,
	output logic [31:0] read_data,
	output logic [6:0]  length
);
	localparam int LW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);

	logic          q_valid, q_pop;
	op_t           q_op;
	kind_t         q_kind;
	status_t       q_status;
	logic [AW-1:0] q_pos;
	logic [31:0]   q_val;
	logic [LW-1:0] q_len;

	iat_front #(.DEPTH(DEPTH), .LW(LW), .AW(AW)) u_front (
		.clk, .arst_n, .start, .busy, .opcode, .position_in, .value_in,
		.q_valid, .q_pop, .q_op, .q_kind, .q_status, .q_pos, .q_val, .q_len
	);

	iat_back #(.DEPTH(DEPTH), .LW(LW), .AW(AW)) u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_op, .q_kind, .q_status, .q_pos,
		.q_val, .q_len, .done, .status, .found, .found_position, .read_data,
		.length
	);
endmodule
